[hdl/nbr_tbl_pkg.sv]
package nbr_tbl_pkg;

  localparam int TABLE_SIZE_DEF = 64;

  localparam int IP_W     = 32;
  localparam int MAC_W    = 48;
  localparam int ORIGIN_W = 8;
  localparam int STATE_W  = 3;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 7;

  localparam int S_FIELDS_W = IP_W + MAC_W + ORIGIN_W + STATE_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = INDEX_W + MAC_W + STATE_W + ORIGIN_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD       = 2'd0,
    CMD_LOOKUP    = 2'd1,
    CMD_SET_STATE = 2'd2,
    CMD_REMOVE    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  localparam logic [STATE_W-1:0] NS_INVALID    = 3'd0;
  localparam logic [STATE_W-1:0] NS_INCOMPLETE = 3'd1;

  // write control broadcast to every cell
  typedef struct packed {
    logic               en;
    logic               on_hit;
    logic               on_free;
    logic               load_key;
    logic               load_mac;
    logic [STATE_W-1:0] state;
  } wr_ctl_t;

  // entry contents gathered along the chain
  typedef struct packed {
    logic [MAC_W-1:0]    mac;
    logic [STATE_W-1:0]  state;
    logic [ORIGIN_W-1:0] origin;
  } entry_rd_t;

endpackage

[hdl/nbr_tbl_cell.sv]
module nbr_tbl_cell #(
  parameter int IW  = 7,
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          capture,
  input  logic [nbr_tbl_pkg::IP_W-1:0]  key,
  input  nbr_tbl_pkg::wr_ctl_t          wr,
  input  logic [nbr_tbl_pkg::IP_W-1:0]  wr_ip,
  input  logic [nbr_tbl_pkg::MAC_W-1:0] wr_mac,
  input  logic [nbr_tbl_pkg::ORIGIN_W-1:0] wr_origin,
  input  logic                          hit_seen_in,
  output logic                          hit_seen_out,
  input  logic                          free_seen_in,
  output logic                          free_seen_out,
  input  logic [IW-1:0]                 hit_idx_in,
  output logic [IW-1:0]                 hit_idx_out,
  input  logic [IW-1:0]                 free_idx_in,
  output logic [IW-1:0]                 free_idx_out,
  input  nbr_tbl_pkg::entry_rd_t        rd_in,
  output nbr_tbl_pkg::entry_rd_t        rd_out
);
  import nbr_tbl_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [STATE_W-1:0]  state;
  logic [IP_W-1:0]     ip;
  logic [MAC_W-1:0]    mac;
  logic [ORIGIN_W-1:0] origin;
  logic                hit;
  logic                free;
  logic                sel_hit;
  logic                sel_free;
  logic                we;

  // lowest cell wins: a cell is picked only if nothing below it was
  assign sel_hit       = hit & ~hit_seen_in;
  assign sel_free      = free & ~free_seen_in;
  assign hit_seen_out  = hit_seen_in | hit;
  assign free_seen_out = free_seen_in | free;
  assign hit_idx_out   = hit_idx_in | (sel_hit ? MY_IDX : '0);
  assign free_idx_out  = free_idx_in | (sel_free ? MY_IDX : '0);

  always_comb begin
    rd_out = rd_in;
    if (sel_hit) begin
      rd_out.mac    = rd_in.mac | mac;
      rd_out.state  = rd_in.state | state;
      rd_out.origin = rd_in.origin | origin;
    end
  end

  assign we = wr.en & ((wr.on_hit & sel_hit) | (wr.on_free & sel_free));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= NS_INVALID;
      hit   <= 1'b0;
      free  <= 1'b0;
    end else begin
      if (capture) begin
        hit  <= (state != NS_INVALID) && (ip == key);
        free <= (state == NS_INVALID);
      end
      if (we) begin
        state <= wr.state;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we && wr.load_key) begin
      ip     <= wr_ip;
      origin <= wr_origin;
    end
    if (we && wr.load_mac) begin
      mac <= wr_mac;
    end
  end

endmodule

[hdl/neighbor_table_unit.sv]
// IPv4 neighbour table with TABLE_SIZE entries, one per cell of a chain.
// Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser; s_tuser carries the
// command (add, lookup, set state, remove) and s_tdata the address, MAC,
// origin tag and new state. Every word gives exactly one result word on
// m_tvalid/m_tready/m_tdata/m_tuser, with the status in m_tuser and the slot
// index, MAC, state and origin in m_tdata.
// Sequence: on the accepting edge every cell compares the address with its own
// entry and flags a hit or a free slot. In the RESOLVE state the priority chain
// picks the lowest hit and lowest free cell, the entry is updated and the
// result is loaded into the output register. s_tready is high only between
// words. The chain length (TABLE_SIZE cells) sets the depth of the priority
// and gather logic in the RESOLVE state.
// If the previous result has not been taken, the RESOLVE state is held until
// the output register frees up, so nothing is dropped; a new word may still
// be accepted while a finished result waits.
// Reset marks every entry invalid at once and empties the output register;
// no clearing pass is needed.
module neighbor_table_unit #(
  parameter int TABLE_SIZE = nbr_tbl_pkg::TABLE_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [31:0] ip_addr, [79:32] mac_in, [87:80] origin_in, [90:88] new_state
  input  logic [nbr_tbl_pkg::S_TDATA_W-1:0] s_tdata,
  // [1:0] command
  input  logic [nbr_tbl_pkg::CMD_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [6:0] entry_index, [54:7] mac_out, [57:55] state_out, [65:58] origin_out
  output logic [nbr_tbl_pkg::M_TDATA_W-1:0] m_tdata,
  // [1:0] status
  output logic [nbr_tbl_pkg::STATUS_W-1:0]  m_tuser
);
  import nbr_tbl_pkg::*;

  localparam int IW = $clog2(TABLE_SIZE + 1);
  localparam logic [IW-1:0] NONE = IW'(TABLE_SIZE);

  typedef enum logic {IDLE, RESOLVE} fsm_t;

  fsm_t                st;
  cmd_t                q_cmd;
  logic [IP_W-1:0]     q_ip;
  logic [MAC_W-1:0]    q_mac;
  logic [ORIGIN_W-1:0] q_origin;
  logic [STATE_W-1:0]  q_state;

  logic                accept;
  logic                commit;
  logic [IP_W-1:0]     in_ip;
  wr_ctl_t             wr;

  logic      hit_seen  [TABLE_SIZE+1];
  logic      free_seen [TABLE_SIZE+1];
  logic [IW-1:0] hit_idx  [TABLE_SIZE+1];
  logic [IW-1:0] free_idx [TABLE_SIZE+1];
  entry_rd_t rd [TABLE_SIZE+1];

  logic                found;
  logic                any_free;
  status_t             res_status;
  logic [IW-1:0]       res_idx;
  logic [IW+INDEX_W-1:0] idx_wide;
  entry_rd_t           res_rd;

  assign s_tready = (st == IDLE);
  assign accept   = s_tvalid & s_tready;
  assign commit   = (st == RESOLVE) && (!m_tvalid || m_tready);
  assign in_ip    = s_tdata[IP_W-1:0];

  assign hit_seen[0]  = 1'b0;
  assign free_seen[0] = 1'b0;
  assign hit_idx[0]   = '0;
  assign free_idx[0]  = '0;
  assign rd[0]        = '0;

  generate
    for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_chain
      nbr_tbl_cell #(
        .IW  (IW),
        .IDX (i)
      ) u_cell (
        .clk           (clk),
        .rst           (rst),
        .capture       (accept),
        .key           (in_ip),
        .wr            (wr),
        .wr_ip         (q_ip),
        .wr_mac        (q_mac),
        .wr_origin     (q_origin),
        .hit_seen_in   (hit_seen[i]),
        .hit_seen_out  (hit_seen[i+1]),
        .free_seen_in  (free_seen[i]),
        .free_seen_out (free_seen[i+1]),
        .hit_idx_in    (hit_idx[i]),
        .hit_idx_out   (hit_idx[i+1]),
        .free_idx_in   (free_idx[i]),
        .free_idx_out  (free_idx[i+1]),
        .rd_in         (rd[i]),
        .rd_out        (rd[i+1])
      );
    end
  endgenerate

  assign found    = hit_seen[TABLE_SIZE];
  assign any_free = free_seen[TABLE_SIZE];

  always_comb begin
    wr          = '0;
    wr.en       = commit;
    res_status  = found ? ST_OK : ST_NOT_FOUND;
    res_idx     = found ? hit_idx[TABLE_SIZE] : NONE;
    res_rd      = '0;
    case (q_cmd)
      CMD_ADD: begin
        wr.on_hit   = found;
        wr.on_free  = ~found;
        wr.load_key = 1'b1;
        wr.load_mac = 1'b1;
        wr.state    = NS_INCOMPLETE;
        if (!found) begin
          res_status = any_free ? ST_OK : ST_FULL;
          res_idx    = any_free ? free_idx[TABLE_SIZE] : NONE;
        end
      end
      CMD_LOOKUP: begin
        if (found) begin
          res_rd = rd[TABLE_SIZE];
        end
      end
      CMD_SET_STATE: begin
        wr.on_hit   = found;
        wr.load_mac = 1'b1;
        wr.state    = q_state;
      end
      CMD_REMOVE: begin
        wr.on_hit = found;
        wr.state  = NS_INVALID;
      end
      default: begin
        wr.on_hit = 1'b0;
      end
    endcase
  end

  assign idx_wide = {{INDEX_W{1'b0}}, res_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready && !commit) begin
        m_tvalid <= 1'b0;
      end
      case (st)
        IDLE: begin
          if (accept) begin
            st <= RESOLVE;
          end
        end
        RESOLVE: begin
          if (commit) begin
            st       <= IDLE;
            m_tvalid <= 1'b1;
          end
        end
        default: begin
          st <= IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_cmd    <= cmd_t'(s_tuser);
      q_ip     <= in_ip;
      q_mac    <= s_tdata[IP_W +: MAC_W];
      q_origin <= s_tdata[IP_W+MAC_W +: ORIGIN_W];
      q_state  <= s_tdata[IP_W+MAC_W+ORIGIN_W +: STATE_W];
    end
    if (commit) begin
      m_tuser <= res_status;
      m_tdata <= {{(M_TDATA_W-M_FIELDS_W){1'b0}}, res_rd.origin, res_rd.state,
                  res_rd.mac, idx_wide[INDEX_W-1:0]};
    end
  end

endmodule
